// ===== src/rrpc_pkg.sv =====
// Shared types, constants and the arctangent table of the rounded-rectangle pixel classifier.
`default_nettype none
package rrpc_pkg;

    // Pixel actions.
    localparam logic [1:0] ACT_UNCH   = 2'd0;
    localparam logic [1:0] ACT_BG     = 2'd1;
    localparam logic [1:0] ACT_SRC    = 2'd2;
    localparam logic [1:0] ACT_BORDER = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_REGION_X = 3'd0;
    localparam logic [2:0] REG_REGION_Y = 3'd1;
    localparam logic [2:0] REG_REGION_W = 3'd2;
    localparam logic [2:0] REG_REGION_H = 3'd3;
    localparam logic [2:0] REG_RADII    = 3'd4;
    localparam logic [2:0] REG_WIDTHS   = 3'd5;
    localparam logic [2:0] REG_SRC_SIZE = 3'd6;
    localparam logic [2:0] REG_FB_SIZE  = 3'd7;

    // Default parameter values.
    localparam int MAX_DIM_DEF      = 4096;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed widths.
    localparam int GW     = 20;   // signed geometry width
    localparam int QUOT_W = 16;   // scaled source coordinate width
    localparam int CORD_W = 32;   // CORDIC vector component width
    localparam int Z_W    = 18;   // CORDIC angle accumulator width
    localparam int ATAN_N = 24;   // table length

    // Per-item classification side data carried along the pipeline.
    typedef struct packed {
        logic        outside;
        logic        fill_src;
        logic        corner;
        logic        edge_bdr;
        logic [7:0]  r;
        logic [7:0]  ws;
        logic [7:0]  wv;
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic        in_box;
        logic        a_zero;
        logic        b_zero;
        logic [15:0] sq_a;
        logic [15:0] sq_b;
        logic [15:0] sq_r;
        logic [16:0] d2;
        logic        in_rad;
        logic        centre;
    } side_t;

    // CORDIC vectoring state.
    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [Z_W-1:0]    z;
    } cord_t;

    // atan(2^-i) in Q1.15 quarter turns, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        v = '0;
        case (idx)
            0:  v = 18'sd16384;
            1:  v = 18'sd9672;
            2:  v = 18'sd5110;
            3:  v = 18'sd2594;
            4:  v = 18'sd1302;
            5:  v = 18'sd652;
            6:  v = 18'sd326;
            7:  v = 18'sd163;
            8:  v = 18'sd81;
            9:  v = 18'sd41;
            10: v = 18'sd20;
            11: v = 18'sd10;
            12: v = 18'sd5;
            13: v = 18'sd3;
            14: v = 18'sd1;
            15: v = 18'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/rrpc_stage.sv =====
// One stage: a CORDIC vectoring step and a restoring-division step per axis, each if in range.
`default_nettype none
module rrpc_stage #(
    parameter int IDX   = 0,
    parameter int STEPS = rrpc_pkg::CORDIC_STEPS_DEF,
    parameter int DW    = 13
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    advance,
    input  wire                    valid_i,
    input  rrpc_pkg::side_t        side_i,
    input  rrpc_pkg::cord_t        cord_i,
    input  wire [DW:0]             rem_x_i,
    input  wire [rrpc_pkg::QUOT_W-1:0] q_x_i,
    input  wire [DW:0]             rem_y_i,
    input  wire [rrpc_pkg::QUOT_W-1:0] q_y_i,
    input  wire [DW-1:0]           den_x,
    input  wire [DW-1:0]           den_y,
    output logic                   valid_o,
    output rrpc_pkg::side_t        side_o,
    output rrpc_pkg::cord_t        cord_o,
    output logic [DW:0]            rem_x_o,
    output logic [rrpc_pkg::QUOT_W-1:0] q_x_o,
    output logic [DW:0]            rem_y_o,
    output logic [rrpc_pkg::QUOT_W-1:0] q_y_o
);

    localparam int RW = DW + 1;
    localparam int QW = rrpc_pkg::QUOT_W;

    logic            valid_reg;
    rrpc_pkg::side_t side_reg;
    rrpc_pkg::cord_t cord_reg, cord_next;
    logic [RW-1:0]   rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QW-1:0]   q_x_reg, q_x_next, q_y_reg, q_y_next;

    // CORDIC step: rotate towards the x axis, steps beyond the count pass through.
    generate
        if (IDX < STEPS && IDX < rrpc_pkg::ATAN_N) begin : g_cord
            always_comb
            begin
                cord_next = cord_i;
                if (cord_i.cy > 0)
                begin
                    cord_next.cx = cord_i.cx + (cord_i.cy >>> IDX);
                    cord_next.cy = cord_i.cy - (cord_i.cx >>> IDX);
                    cord_next.z  = cord_i.z + rrpc_pkg::atan_entry(IDX);
                end
                else
                begin
                    cord_next.cx = cord_i.cx - (cord_i.cy >>> IDX);
                    cord_next.cy = cord_i.cy + (cord_i.cx >>> IDX);
                    cord_next.z  = cord_i.z - rrpc_pkg::atan_entry(IDX);
                end
            end
        end else begin : g_cord_pass
            assign cord_next = cord_i;
        end
    endgenerate

    // Division step: shift in the next dividend bit, subtract when it fits.
    generate
        if (IDX < QW) begin : g_div
            logic [RW-1:0] sh_x, sh_y;
            always_comb
            begin
                sh_x = {rem_x_i[DW-1:0], q_x_i[QW-1]};
                sh_y = {rem_y_i[DW-1:0], q_y_i[QW-1]};
                if (sh_x >= {1'b0, den_x})
                begin
                    rem_x_next = sh_x - {1'b0, den_x};
                    q_x_next   = {q_x_i[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_x_next = sh_x;
                    q_x_next   = {q_x_i[QW-2:0], 1'b0};
                end
                if (sh_y >= {1'b0, den_y})
                begin
                    rem_y_next = sh_y - {1'b0, den_y};
                    q_y_next   = {q_y_i[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_y_next = sh_y;
                    q_y_next   = {q_y_i[QW-2:0], 1'b0};
                end
            end
        end else begin : g_div_pass
            assign rem_x_next = rem_x_i;
            assign rem_y_next = rem_y_i;
            assign q_x_next   = q_x_i;
            assign q_y_next   = q_y_i;
        end
    endgenerate

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_i;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg  <= side_i;
            cord_reg  <= cord_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
        end
    end

    assign valid_o = valid_reg;
    assign side_o  = side_reg;
    assign cord_o  = cord_reg;
    assign rem_x_o = rem_x_reg;
    assign rem_y_o = rem_y_reg;
    assign q_x_o   = q_x_reg;
    assign q_y_o   = q_y_reg;

endmodule
`default_nettype wire

// ===== src/rounded_rect_pixel_classifier.sv =====
// Top level of the rounded-rectangle pixel classifier pipeline.
// Usage: write the eight configuration registers through cfg_we, cfg_index and
// cfg_data while no pixel is in flight; a write takes effect at its clock edge.
// Pixels enter on in_valid with pixel_x and pixel_y; a transfer happens at an
// edge where in_valid is high and in_stall is low. Each pixel yields one result
// on out_valid with action, src_x and src_y, transferred when out_stall is low.
// Throughput is one pixel per clock while no result is held. A pixel passes
// from the input transfer to out_valid through five setup
// stages, one stage per CORDIC step or quotient bit, and four stages for the
// border width, its square and the final decision.
// A stalled result holds the whole pipeline: in_stall follows a held result,
// so nothing is lost or repeated and bubbles stay where they are.
// Reset clears every valid bit and the configuration registers to zero.
`default_nettype none
module rounded_rect_pixel_classifier #(
    parameter int MAX_DIM      = rrpc_pkg::MAX_DIM_DEF,
    parameter int CORDIC_STEPS = rrpc_pkg::CORDIC_STEPS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [11:0] pixel_x,
    input  wire  [11:0] pixel_y,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  action,
    output logic [15:0] src_x,
    output logic [15:0] src_y
);

    localparam int GW   = rrpc_pkg::GW;
    localparam int QW   = rrpc_pkg::QUOT_W;
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int RW   = DW + 1;
    localparam int MIDL = (CORDIC_STEPS > QW) ? CORDIC_STEPS : QW;
    localparam logic [15:0] T_FULL = 16'h8000;

    // Configuration registers.
    logic [15:0] region_x_reg, region_y_reg, region_w_reg, region_h_reg;
    logic [31:0] radii_reg, widths_reg, src_size_reg, fb_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_x_reg <= '0;
            region_y_reg <= '0;
            region_w_reg <= '0;
            region_h_reg <= '0;
            radii_reg    <= '0;
            widths_reg   <= '0;
            src_size_reg <= '0;
            fb_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrpc_pkg::REG_REGION_X: region_x_reg <= cfg_data[15:0];
                rrpc_pkg::REG_REGION_Y: region_y_reg <= cfg_data[15:0];
                rrpc_pkg::REG_REGION_W: region_w_reg <= cfg_data[15:0];
                rrpc_pkg::REG_REGION_H: region_h_reg <= cfg_data[15:0];
                rrpc_pkg::REG_RADII:    radii_reg    <= cfg_data;
                rrpc_pkg::REG_WIDTHS:   widths_reg   <= cfg_data;
                rrpc_pkg::REG_SRC_SIZE: src_size_reg <= cfg_data;
                rrpc_pkg::REG_FB_SIZE:  fb_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Static geometry derived from the configuration.
    logic signed [GW-1:0] rx, ry, rw, rh, fbw, fbh, rxw, ryh;
    logic signed [GW-1:0] sx_next, sy_next, ex_next, ey_next;
    logic signed [GW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [DW-1:0]        den_x_next, den_y_next, den_x_reg, den_y_reg;

    always_comb
    begin
        rx  = GW'($signed(region_x_reg));
        ry  = GW'($signed(region_y_reg));
        rw  = $signed({4'b0, region_w_reg});
        rh  = $signed({4'b0, region_h_reg});
        fbw = ({1'b0, fb_size_reg[15:0]} > 17'(MAX_DIM)) ? GW'(MAX_DIM)
                                                           : $signed({4'b0, fb_size_reg[15:0]});
        fbh = ({1'b0, fb_size_reg[31:16]} > 17'(MAX_DIM)) ? GW'(MAX_DIM)
                                                            : $signed({4'b0, fb_size_reg[31:16]});
        sx_next = (rx < 0) ? '0 : ((rx > fbw) ? fbw : rx);
        sy_next = (ry < 0) ? '0 : ((ry > fbh) ? fbh : ry);
        rxw = rx + rw;
        ryh = ry + rh;
        ex_next = (rxw < sx_next) ? sx_next : ((rxw > fbw) ? fbw : rxw);
        ey_next = (ryh < sy_next) ? sy_next : ((ryh > fbh) ? fbh : ryh);
        den_x_next = DW'(ex_next - sx_next);
        den_y_next = DW'(ey_next - sy_next);
    end

    // The clipped bounds are registered so that the clamp chain stays out of stage 2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_reg    <= '0;
            ey_reg    <= '0;
            den_x_reg <= '0;
            den_y_reg <= '0;
        end
        else
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            den_x_reg <= den_x_next;
            den_y_reg <= den_y_next;
        end
    end

    // Pipeline advances unless a finished result is held.
    logic advance;
    logic out_valid_reg;
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Stage 1: input register.
    logic        s1_valid_reg;
    logic [11:0] s1_x_reg, s1_y_reg;

    // Stage 2: clipping, corner selection and straight-edge test.
    logic                 s2_valid_reg;
    rrpc_pkg::side_t      s2_side_reg, s2_side_next;
    logic [11:0]          s2_x_reg, s2_y_reg, s2_ox_reg, s2_oy_reg, s2_ox_next, s2_oy_next;
    logic signed [GW-1:0] s2_cx_reg, s2_cy_reg, s2_cx_next, s2_cy_next;

    always_comb
    begin
        logic signed [GW-1:0] xs, ys, r_tl, r_tr, r_bl, r_br;
        logic signed [GW-1:0] w_top, w_bot, w_lft, w_rgt;
        xs    = $signed({8'b0, s1_x_reg});
        ys    = $signed({8'b0, s1_y_reg});
        r_tl  = $signed({12'b0, radii_reg[7:0]});
        r_tr  = $signed({12'b0, radii_reg[15:8]});
        r_bl  = $signed({12'b0, radii_reg[23:16]});
        r_br  = $signed({12'b0, radii_reg[31:24]});
        w_top = $signed({12'b0, widths_reg[7:0]});
        w_bot = $signed({12'b0, widths_reg[15:8]});
        w_lft = $signed({12'b0, widths_reg[23:16]});
        w_rgt = $signed({12'b0, widths_reg[31:24]});

        s2_side_next          = '0;
        s2_side_next.outside  = (xs < sx_reg) || (xs >= ex_reg) ||
                                (ys < sy_reg) || (ys >= ey_reg);
        s2_side_next.fill_src = (src_size_reg != '0);
        s2_side_next.edge_bdr = ((ys - sy_reg) < w_top) || ((ey_reg - ys) <= w_bot) ||
                                ((xs - sx_reg) < w_lft) || ((ex_reg - xs) <= w_rgt);
        s2_ox_next = 12'(xs - sx_reg);
        s2_oy_next = 12'(ys - sy_reg);

        // Corners in priority order: top-left, top-right, bottom-left, bottom-right.
        s2_side_next.corner = 1'b1;
        if (ys <= ry + r_tl && xs <= rx + r_tl)
        begin
            s2_cx_next = rx + r_tl;
            s2_cy_next = ry + r_tl;
            s2_side_next.r  = radii_reg[7:0];
            s2_side_next.ws = widths_reg[23:16];
            s2_side_next.wv = widths_reg[7:0];
        end
        else if (ys <= ry + r_tr && xs >= rxw - r_tr)
        begin
            s2_cx_next = rxw - r_tr;
            s2_cy_next = ry + r_tr;
            s2_side_next.r  = radii_reg[15:8];
            s2_side_next.ws = widths_reg[31:24];
            s2_side_next.wv = widths_reg[7:0];
        end
        else if (ys >= ryh - r_bl && xs <= rx + r_bl)
        begin
            s2_cx_next = rx + r_bl;
            s2_cy_next = ryh - r_bl;
            s2_side_next.r  = radii_reg[23:16];
            s2_side_next.ws = widths_reg[23:16];
            s2_side_next.wv = widths_reg[15:8];
        end
        else if (ys >= ryh - r_br && xs >= rxw - r_br)
        begin
            s2_cx_next = rxw - r_br;
            s2_cy_next = ryh - r_br;
            s2_side_next.r  = radii_reg[31:24];
            s2_side_next.ws = widths_reg[31:24];
            s2_side_next.wv = widths_reg[15:8];
        end
        else
        begin
            s2_cx_next = xs;
            s2_cy_next = ys;
            s2_side_next.corner = 1'b0;
        end
    end

    // Stage 3: distances from the corner centre and the scaling products.
    logic            s3_valid_reg;
    rrpc_pkg::side_t s3_side_reg, s3_side_next;
    logic [27:0]     s3_px_reg, s3_py_reg;

    always_comb
    begin
        logic signed [GW-1:0] dx, dy;
        logic [GW-1:0]        a, b;
        dx = $signed({8'b0, s2_x_reg}) - s2_cx_reg;
        dy = $signed({8'b0, s2_y_reg}) - s2_cy_reg;
        a  = (dx < 0) ? GW'(-dx) : GW'(dx);
        b  = (dy < 0) ? GW'(-dy) : GW'(dy);
        s3_side_next        = s2_side_reg;
        s3_side_next.a8     = a[7:0];
        s3_side_next.b8     = b[7:0];
        s3_side_next.in_box = (a <= GW'(s2_side_reg.r)) && (b <= GW'(s2_side_reg.r));
        s3_side_next.a_zero = (a == '0);
        s3_side_next.b_zero = (b == '0);
    end

    // Stage 4: squares.
    logic            s4_valid_reg;
    rrpc_pkg::side_t s4_side_reg, s4_side_next;
    logic [27:0]     s4_px_reg, s4_py_reg;

    always_comb
    begin
        s4_side_next      = s3_side_reg;
        s4_side_next.sq_a = s3_side_reg.a8 * s3_side_reg.a8;
        s4_side_next.sq_b = s3_side_reg.b8 * s3_side_reg.b8;
        s4_side_next.sq_r = s3_side_reg.r * s3_side_reg.r;
    end

    // Stage 5: radius test and start of CORDIC and division.
    logic            s5_valid_reg;
    rrpc_pkg::side_t s5_side_reg, s5_side_next;
    rrpc_pkg::cord_t s5_cord_reg, s5_cord_next;
    logic [RW-1:0]   s5_rem_x_reg, s5_rem_y_reg;
    logic [QW-1:0]   s5_q_x_reg, s5_q_y_reg;

    always_comb
    begin
        s5_side_next        = s4_side_reg;
        s5_side_next.d2     = {1'b0, s4_side_reg.sq_a} + {1'b0, s4_side_reg.sq_b};
        s5_side_next.in_rad = s4_side_reg.in_box &&
                              (s5_side_next.d2 <= {1'b0, s4_side_reg.sq_r});
        s5_side_next.centre = s4_side_reg.a_zero && s4_side_reg.b_zero;
        s5_cord_next.cx     = $signed({4'b0, s4_side_reg.a8, 20'b0});
        s5_cord_next.cy     = $signed({4'b0, s4_side_reg.b8, 20'b0});
        s5_cord_next.z      = '0;
    end

    // Early stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg     <= pixel_x;
            s1_y_reg     <= pixel_y;
            s2_side_reg  <= s2_side_next;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_ox_reg    <= s2_ox_next;
            s2_oy_reg    <= s2_oy_next;
            s2_cx_reg    <= s2_cx_next;
            s2_cy_reg    <= s2_cy_next;
            s3_side_reg  <= s3_side_next;
            s3_px_reg    <= s2_ox_reg * src_size_reg[15:0];
            s3_py_reg    <= s2_oy_reg * src_size_reg[31:16];
            s4_side_reg  <= s4_side_next;
            s4_px_reg    <= s3_px_reg;
            s4_py_reg    <= s3_py_reg;
            s5_side_reg  <= s5_side_next;
            s5_cord_reg  <= s5_cord_next;
            s5_rem_x_reg <= RW'(s4_px_reg[27:16]);
            s5_rem_y_reg <= RW'(s4_py_reg[27:16]);
            s5_q_x_reg   <= s4_px_reg[15:0];
            s5_q_y_reg   <= s4_py_reg[15:0];
        end
    end

    // Iterative section: one CORDIC step and one quotient bit per stage, while steps or bits remain.
    logic            mid_valid [0:MIDL];
    rrpc_pkg::side_t mid_side  [0:MIDL];
    rrpc_pkg::cord_t mid_cord  [0:MIDL];
    logic [RW-1:0]   mid_rem_x [0:MIDL];
    logic [RW-1:0]   mid_rem_y [0:MIDL];
    logic [QW-1:0]   mid_q_x   [0:MIDL];
    logic [QW-1:0]   mid_q_y   [0:MIDL];

    assign mid_valid[0] = s5_valid_reg;
    assign mid_side[0]  = s5_side_reg;
    assign mid_cord[0]  = s5_cord_reg;
    assign mid_rem_x[0] = s5_rem_x_reg;
    assign mid_rem_y[0] = s5_rem_y_reg;
    assign mid_q_x[0]   = s5_q_x_reg;
    assign mid_q_y[0]   = s5_q_y_reg;

    generate
        for (genvar i = 0; i < MIDL; i++) begin : g_mid
            rrpc_stage #(
                .IDX   (i),
                .STEPS (CORDIC_STEPS),
                .DW    (DW)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .valid_i (mid_valid[i]),
                .side_i  (mid_side[i]),
                .cord_i  (mid_cord[i]),
                .rem_x_i (mid_rem_x[i]),
                .q_x_i   (mid_q_x[i]),
                .rem_y_i (mid_rem_y[i]),
                .q_y_i   (mid_q_y[i]),
                .den_x   (den_x_reg),
                .den_y   (den_y_reg),
                .valid_o (mid_valid[i+1]),
                .side_o  (mid_side[i+1]),
                .cord_o  (mid_cord[i+1]),
                .rem_x_o (mid_rem_x[i+1]),
                .q_x_o   (mid_q_x[i+1]),
                .rem_y_o (mid_rem_y[i+1]),
                .q_y_o   (mid_q_y[i+1])
            );
        end
    endgenerate

    // E1: angle clamp and width blend products.
    logic            e1_valid_reg;
    rrpc_pkg::side_t e1_side_reg;
    logic [23:0]     e1_ph_reg, e1_pv_reg;
    logic [QW-1:0]   e1_q_x_reg, e1_q_y_reg;
    logic [15:0]     e1_t;

    always_comb
    begin
        logic signed [rrpc_pkg::Z_W-1:0] z;
        z = mid_cord[MIDL].z;
        if (mid_side[MIDL].b_zero)
            e1_t = '0;
        else if (mid_side[MIDL].a_zero)
            e1_t = T_FULL;
        else if (z < 0)
            e1_t = '0;
        else if (z > $signed({2'b0, T_FULL}))
            e1_t = T_FULL;
        else
            e1_t = z[15:0];
    end

    // E2: blended width and inner radius.
    logic                 e2_valid_reg;
    rrpc_pkg::side_t      e2_side_reg;
    logic                 e2_m_pos_reg;
    logic [15:0]          e2_m_reg;
    logic [QW-1:0]        e2_q_x_reg, e2_q_y_reg;
    logic [24:0]          e2_sum;
    logic signed [18:0]   e2_m;

    always_comb
    begin
        e2_sum = {1'b0, e1_ph_reg} + {1'b0, e1_pv_reg} + 25'd64;
        e2_m   = $signed({3'b0, e1_side_reg.r, 8'b0}) - $signed({1'b0, e2_sum[24:7]});
    end

    // E3: square of the inner radius.
    logic            e3_valid_reg;
    rrpc_pkg::side_t e3_side_reg;
    logic            e3_m_pos_reg;
    logic [31:0]     e3_mm_reg;
    logic [QW-1:0]   e3_q_x_reg, e3_q_y_reg;

    // Output stage: final decision.
    logic [1:0]  action_reg, action_next;
    logic [15:0] src_x_reg, src_y_reg;

    always_comb
    begin
        logic [1:0] fill;
        logic       bdr;
        fill = e3_side_reg.fill_src ? rrpc_pkg::ACT_SRC : rrpc_pkg::ACT_BG;
        bdr  = !e3_m_pos_reg || ({e3_side_reg.d2, 16'b0} >= {1'b0, e3_mm_reg});
        if (e3_side_reg.outside)
            action_next = rrpc_pkg::ACT_UNCH;
        else if (e3_side_reg.corner)
        begin
            if (!e3_side_reg.in_rad)
                action_next = rrpc_pkg::ACT_UNCH;
            else if (e3_side_reg.centre)
                action_next = fill;
            else
                action_next = bdr ? rrpc_pkg::ACT_BORDER : fill;
        end
        else
            action_next = e3_side_reg.edge_bdr ? rrpc_pkg::ACT_BORDER : fill;
    end

    // Late stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e1_valid_reg  <= mid_valid[MIDL];
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            out_valid_reg <= e3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e1_side_reg  <= mid_side[MIDL];
            e1_ph_reg    <= mid_side[MIDL].ws * (T_FULL - e1_t);
            e1_pv_reg    <= mid_side[MIDL].wv * e1_t;
            e1_q_x_reg   <= mid_q_x[MIDL];
            e1_q_y_reg   <= mid_q_y[MIDL];
            e2_side_reg  <= e1_side_reg;
            e2_m_pos_reg <= (e2_m > 0);
            e2_m_reg     <= e2_m[15:0];
            e2_q_x_reg   <= e1_q_x_reg;
            e2_q_y_reg   <= e1_q_y_reg;
            e3_side_reg  <= e2_side_reg;
            e3_m_pos_reg <= e2_m_pos_reg;
            e3_mm_reg    <= e2_m_reg * e2_m_reg;
            e3_q_x_reg   <= e2_q_x_reg;
            e3_q_y_reg   <= e2_q_y_reg;
            action_reg   <= action_next;
            src_x_reg    <= (action_next == rrpc_pkg::ACT_SRC) ? e3_q_x_reg : '0;
            src_y_reg    <= (action_next == rrpc_pkg::ACT_SRC) ? e3_q_y_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;

    // Source coordinates are only shown with a source texel.
    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != rrpc_pkg::ACT_SRC |-> src_x == '0 && src_y == '0)
        else $error("source coordinate not cleared");

    // Input is held off only while a result waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall without a held result");

    // A held pipeline keeps its result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(action) && $stable(src_x) && $stable(src_y) && out_valid)
        else $error("held result changed");

endmodule
`default_nettype wire
